// File: design/ac_current_peak_tracker_top_macros.svh
// Assertion macros for the AC current peak tracker.
`ifndef AC_CURRENT_PEAK_TRACKER_TOP_MACROS_SVH
`define AC_CURRENT_PEAK_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ACPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ACPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/acpt_pkg.sv
// Shared types, constants and arithmetic helpers for the AC current peak tracker.
package acpt_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned WeightW = 7;
  localparam int unsigned WindowW = 10;
  localparam int unsigned ProdW   = 2 * SampleW;
  localparam int unsigned BlendW  = 19;

  localparam logic [SampleW-1:0] VrefReset   = 12'd3300;
  localparam logic [WeightW-1:0] WeightReset = 7'd10;
  localparam logic [WindowW-1:0] WindowReset = 10'd50;
  localparam logic [SampleW-1:0] AvgReset    = 12'(3300 / 2);
  localparam logic [WeightW-1:0] WeightFull  = 7'd100;
  localparam logic [SampleW-1:0] MaOffsetMv  = 12'd15;
  localparam logic [6:0]         MaScale     = 7'(890 / 10);  // 890/1000 == 89/100

  // Reciprocal of 100 in 2^-25 units; exact for inputs up to 493447, and
  // blend sums and mA products stay below 409600.
  localparam int unsigned  Div100Shift = 25;
  localparam logic [18:0]  Div100Recip = 19'd335545;

  localparam logic KIND_CONV = 1'b0;
  localparam logic KIND_EOS  = 1'b1;

  typedef enum logic [1:0] {
    CFG_VREF  = 2'd0,
    CFG_REF_W = 2'd1,
    CFG_CUR_W = 2'd2,
    CFG_WIN   = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    RANK_REF  = 4'b0001,
    RANK_C0   = 4'b0010,
    RANK_C1   = 4'b0100,
    RANK_IDLE = 4'b1000
  } rank_e;

  function automatic logic [WeightW-1:0] sat_weight(input logic [WeightW-1:0] w);
    return (w > WeightFull) ? WeightFull : w;
  endfunction

  // floor(x / 100) for x <= 493447
  function automatic logic [SampleW-1:0] div100(input logic [BlendW-1:0] x);
    logic [37:0] p;
    p = 38'(x) * 38'(Div100Recip);
    return p[Div100Shift+SampleW-1:Div100Shift];
  endfunction

  // floor(x / 4095) for x < 2^24: estimate, then one correction step
  function automatic logic [SampleW-1:0] div4095(input logic [ProdW-1:0] x);
    logic [ProdW:0]   s;
    logic [12:0]      q0;
    logic [ProdW:0]   r;
    s  = {1'b0, x} + (ProdW+1)'(x >> 12);
    q0 = s[ProdW:12];
    r  = {1'b0, x} + (ProdW+1)'(q0) - ((ProdW+1)'(q0) << 12);
    if (r >= (ProdW+1)'(4095)) begin
      q0 = q0 + 13'd1;
    end
    return q0[SampleW-1:0];
  endfunction

endpackage

// File: design/ac_current_peak_tracker_top.sv
// Top level of the AC current peak tracker: pipeline, tracker state and result register.
//
// Usage:
//  - Slave stream carries converter events: tuser is the kind (0 conversion
//    result, 1 end of sequence), tdata[11:0] the raw 12-bit code.
//  - Master stream returns one result per accepted event, in order:
//    both averaged channel currents in mA and the averaged reference in mV.
//  - Config port: cfg_we_i writes cfg_idx_i (0 vref_mv, 1 reference weight,
//    2 current weight, 3 window length) with cfg_data_i, no
//    read-back. Write only while the pipeline is empty.
//  - Throughput is one request per cycle when nothing stalls; the tracker
//    update (blend multiply plus divide by 100 on the state feedback) is
//    combinational within its stage, and that is what holds that figure.
//  - Stages: input reg, raw*vref product, mV conversion and weighted sample,
//    tracker state update, mA scaling, divide by 100 into the output reg.
//  - Stalls: each stage holds while its successor is full and not moving;
//    empty stages fill, so requests are still taken while a result waits
//    until all six stages are occupied.
//  - Reset: config returns to 3300 mV, weights 10, window 50; averages to
//    1650, peaks and sequence count to 0, rank to reference, pipeline empty.

`include "ac_current_peak_tracker_top_macros.svh"

module ac_current_peak_tracker_top (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [11:0] raw_sample, [15:12] zero
  input  logic        s_axis_tuser_i,   // [0] kind

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [11:0] current0_ma, [23:12] current1_ma,
                                        // [35:24] reference_mv, [39:36] zero

  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [11:0] cfg_data_i
);

  // ---------------- configuration registers ----------------
  logic [acpt_pkg::SampleW-1:0] vref_q;
  logic [acpt_pkg::WeightW-1:0] ref_w_q, cur_w_q;
  logic [acpt_pkg::WindowW-1:0] win_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vref_q  <= acpt_pkg::VrefReset;
      ref_w_q <= acpt_pkg::WeightReset;
      cur_w_q <= acpt_pkg::WeightReset;
      win_q   <= acpt_pkg::WindowReset;
    end else if (cfg_we_i) begin
      case (acpt_pkg::cfg_idx_e'(cfg_idx_i))
        acpt_pkg::CFG_VREF:  vref_q  <= cfg_data_i[acpt_pkg::SampleW-1:0];
        acpt_pkg::CFG_REF_W: ref_w_q <= cfg_data_i[acpt_pkg::WeightW-1:0];
        acpt_pkg::CFG_CUR_W: cur_w_q <= cfg_data_i[acpt_pkg::WeightW-1:0];
        acpt_pkg::CFG_WIN:   win_q   <= cfg_data_i[acpt_pkg::WindowW-1:0];
        default: ;
      endcase
    end
  end

  logic [acpt_pkg::WeightW-1:0] ref_ws, cur_ws;
  assign ref_ws = acpt_pkg::sat_weight(ref_w_q);
  assign cur_ws = acpt_pkg::sat_weight(cur_w_q);

  // ---------------- pipeline flow control ----------------
  // Stage k loads when it is empty or its content moves on.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_q || m_axis_tready_i;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic                         kind1_q;
  logic [acpt_pkg::SampleW-1:0] raw1_q;

  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid_i) begin
      kind1_q <= s_axis_tuser_i;
      raw1_q  <= s_axis_tdata_i[acpt_pkg::SampleW-1:0];
    end
  end

  // ---------------- stage 2: raw * vref ----------------
  logic                       kind2_q;
  logic [acpt_pkg::ProdW-1:0] prod2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      kind2_q <= kind1_q;
      prod2_q <= acpt_pkg::ProdW'(raw1_q) * acpt_pkg::ProdW'(vref_q);
    end
  end

  // ---------------- stage 3: mV and weighted sample ----------------
  logic                         kind3_q;
  logic [acpt_pkg::SampleW-1:0] mv3_q;
  logic [acpt_pkg::BlendW-1:0]  wmv3_q;
  logic [acpt_pkg::SampleW-1:0] mv2;

  assign mv2 = acpt_pkg::div4095(prod2_q);

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      kind3_q <= kind2_q;
      mv3_q   <= mv2;
      wmv3_q  <= acpt_pkg::BlendW'(ref_ws) * acpt_pkg::BlendW'(mv2);
    end
  end

  // ---------------- stage 4: tracker state ----------------
  logic [acpt_pkg::SampleW-1:0] ref_avg_q, ref_avg_d;
  logic [acpt_pkg::SampleW-1:0] c0_avg_q, c0_avg_d, c1_avg_q, c1_avg_d;
  logic [acpt_pkg::SampleW-1:0] c0_peak_q, c0_peak_d, c1_peak_q, c1_peak_d;
  logic [acpt_pkg::WindowW-1:0] tally_q, tally_d;
  acpt_pkg::rank_e              rank_q, rank_d;

  logic                         upd;
  logic [acpt_pkg::SampleW-1:0] diff;
  logic [acpt_pkg::WindowW:0]   tally_inc;
  logic                         fold;
  logic [acpt_pkg::WeightW-1:0] ref_keep, cur_keep;
  logic [acpt_pkg::BlendW-1:0]  ref_sum, c0_sum, c1_sum;

  assign upd       = rdy4 && v3_q;
  assign diff      = (ref_avg_q > mv3_q) ? (ref_avg_q - mv3_q) : (mv3_q - ref_avg_q);
  assign tally_inc = {1'b0, tally_q} + (acpt_pkg::WindowW+1)'(1);
  assign fold      = tally_inc > {1'b0, win_q};

  assign ref_keep = acpt_pkg::WeightFull - ref_ws;
  assign cur_keep = acpt_pkg::WeightFull - cur_ws;
  assign ref_sum  = wmv3_q + acpt_pkg::BlendW'(ref_keep) * acpt_pkg::BlendW'(ref_avg_q);
  assign c0_sum   = acpt_pkg::BlendW'(cur_ws) * acpt_pkg::BlendW'(c0_peak_q)
                  + acpt_pkg::BlendW'(cur_keep) * acpt_pkg::BlendW'(c0_avg_q);
  assign c1_sum   = acpt_pkg::BlendW'(cur_ws) * acpt_pkg::BlendW'(c1_peak_q)
                  + acpt_pkg::BlendW'(cur_keep) * acpt_pkg::BlendW'(c1_avg_q);

  always_comb begin
    ref_avg_d = ref_avg_q;
    c0_avg_d  = c0_avg_q;
    c1_avg_d  = c1_avg_q;
    c0_peak_d = c0_peak_q;
    c1_peak_d = c1_peak_q;
    tally_d   = tally_q;
    rank_d    = rank_q;
    if (kind3_q == acpt_pkg::KIND_CONV) begin
      case (rank_q)
        acpt_pkg::RANK_REF: begin
          ref_avg_d = acpt_pkg::div100(ref_sum);
          rank_d    = acpt_pkg::RANK_C0;
        end
        acpt_pkg::RANK_C0: begin
          if (diff > c0_peak_q) c0_peak_d = diff;
          rank_d = acpt_pkg::RANK_C1;
        end
        acpt_pkg::RANK_C1: begin
          if (diff > c1_peak_q) c1_peak_d = diff;
          rank_d = acpt_pkg::RANK_IDLE;
        end
        default: ;  // idle rank: conversion ignored
      endcase
    end else begin
      rank_d = acpt_pkg::RANK_REF;
      if (fold) begin
        c0_avg_d  = acpt_pkg::div100(c0_sum);
        c1_avg_d  = acpt_pkg::div100(c1_sum);
        c0_peak_d = '0;
        c1_peak_d = '0;
        tally_d   = '0;
      end else begin
        tally_d = tally_inc[acpt_pkg::WindowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_avg_q <= acpt_pkg::AvgReset;
      c0_avg_q  <= acpt_pkg::AvgReset;
      c1_avg_q  <= acpt_pkg::AvgReset;
      c0_peak_q <= '0;
      c1_peak_q <= '0;
      tally_q   <= '0;
      rank_q    <= acpt_pkg::RANK_REF;
    end else if (upd) begin
      ref_avg_q <= ref_avg_d;
      c0_avg_q  <= c0_avg_d;
      c1_avg_q  <= c1_avg_d;
      c0_peak_q <= c0_peak_d;
      c1_peak_q <= c1_peak_d;
      tally_q   <= tally_d;
      rank_q    <= rank_d;
    end
  end

  // snapshot of the post-update averages for this request
  logic [acpt_pkg::SampleW-1:0] c0_4_q, c1_4_q, ref4_q;

  always_ff @(posedge clk_i) begin
    if (upd) begin
      c0_4_q <= c0_avg_d;
      c1_4_q <= c1_avg_d;
      ref4_q <= ref_avg_d;
    end
  end

  // ---------------- stage 5: mA scaling ----------------
  logic [acpt_pkg::SampleW-1:0] c0_off, c1_off;
  logic [acpt_pkg::BlendW-1:0]  c0_5_q, c1_5_q;
  logic [acpt_pkg::SampleW-1:0] ref5_q;

  assign c0_off = (c0_4_q > acpt_pkg::MaOffsetMv) ? (c0_4_q - acpt_pkg::MaOffsetMv) : '0;
  assign c1_off = (c1_4_q > acpt_pkg::MaOffsetMv) ? (c1_4_q - acpt_pkg::MaOffsetMv) : '0;

  always_ff @(posedge clk_i) begin
    if (rdy5 && v4_q) begin
      c0_5_q <= acpt_pkg::BlendW'(c0_off) * acpt_pkg::BlendW'(acpt_pkg::MaScale);
      c1_5_q <= acpt_pkg::BlendW'(c1_off) * acpt_pkg::BlendW'(acpt_pkg::MaScale);
      ref5_q <= ref4_q;
    end
  end

  // ---------------- stage 6: output register ----------------
  logic [acpt_pkg::SampleW-1:0] c0_6_q, c1_6_q, ref6_q;

  always_ff @(posedge clk_i) begin
    if (rdy6 && v5_q) begin
      c0_6_q <= acpt_pkg::div100(c0_5_q);
      c1_6_q <= acpt_pkg::div100(c1_5_q);
      ref6_q <= ref5_q;
    end
  end

  assign m_axis_tvalid_o = v6_q;
  assign m_axis_tdata_o  = {4'b0000, ref6_q, c1_6_q, c0_6_q};

  // ---------------- assertions ----------------
  `ACPT_ASSERT_NEXT(a_state_hold, !upd, $stable(ref_avg_q) && $stable(tally_q),
                    "tracker state changed without a request in the update stage")
  `ACPT_ASSERT_NEXT(a_fold_clears, upd && kind3_q == acpt_pkg::KIND_EOS && fold,
                    c0_peak_q == '0 && c1_peak_q == '0 && tally_q == '0,
                    "window fold did not clear peaks and count")
  `ACPT_ASSERT_NOW(a_ready_full, !s_axis_tready_o,
                   v1_q && v2_q && v3_q && v4_q && v5_q && v6_q,
                   "input stalled while a pipeline stage is empty")

endmodule
